### src/c8ex_pkg.sv
`timescale 1ns / 1ps
// Shared constants, opcode codes and transfer structs for the CHIP-8 execute block.
// No dependencies; every other file imports this package.
package c8ex_pkg;

    localparam int INSTR_W     = 16;
    localparam int PC_W        = 12;
    localparam int DATA_W      = 8;
    localparam int IDX_W       = 4;
    localparam int DEPTH_OUT_W = 5;
    localparam int NUM_V       = 16;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [PC_W-1:0]    START_RESET = 12'h200;
    localparam logic [IDX_W-1:0]   VF_IDX      = 4'hF;
    localparam logic [INSTR_W-1:0] W_RET       = 16'h00EE;

    localparam logic [3:0] OP_SYS    = 4'h0;
    localparam logic [3:0] OP_JP     = 4'h1;
    localparam logic [3:0] OP_CALL   = 4'h2;
    localparam logic [3:0] OP_SE_K   = 4'h3;
    localparam logic [3:0] OP_SNE_K  = 4'h4;
    localparam logic [3:0] OP_SE_R   = 4'h5;
    localparam logic [3:0] OP_LD_K   = 4'h6;
    localparam logic [3:0] OP_ADD_K  = 4'h7;
    localparam logic [3:0] OP_ALU    = 4'h8;

    localparam logic [3:0] ALU_LD    = 4'h0;
    localparam logic [3:0] ALU_OR    = 4'h1;
    localparam logic [3:0] ALU_AND   = 4'h2;
    localparam logic [3:0] ALU_XOR   = 4'h3;
    localparam logic [3:0] ALU_ADD   = 4'h4;
    localparam logic [3:0] ALU_SUB   = 4'h5;
    localparam logic [3:0] ALU_SHR   = 4'h6;
    localparam logic [3:0] ALU_SUBN  = 4'h7;
    localparam logic [3:0] ALU_SHL   = 4'hE;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              reg_written;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] reg_value;
        logic              flag_value;
        logic              skip_taken;
        logic              stack_error;
    } t_result;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [PC_W-1:0] push_addr;
    } t_stack_op;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic              vf_we;
        logic [DATA_W-1:0] vf_data;
    } t_vwrite;

endpackage

### src/c8ex_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instruction input and execute result output.
// Depends on c8ex_pkg for field widths.
interface c8ex_in_if;
    import c8ex_pkg::*;
    logic               valid;
    logic               ready;
    logic [INSTR_W-1:0] instruction_word;
    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface c8ex_out_if;
    import c8ex_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [PC_W-1:0]        next_pc;
    logic                   reg_written;
    logic [IDX_W-1:0]       reg_index;
    logic [DATA_W-1:0]      reg_value;
    logic                   flag_value;
    logic                   skip_taken;
    logic [DEPTH_OUT_W-1:0] stack_depth;
    logic                   stack_error;
    modport source (output valid, output next_pc, output reg_written, output reg_index,
                    output reg_value, output flag_value, output skip_taken,
                    output stack_depth, output stack_error, input ready);
    modport sink   (input valid, input next_pc, input reg_written, input reg_index,
                    input reg_value, input flag_value, input skip_taken,
                    input stack_depth, input stack_error, output ready);
endinterface

### src/chip8_control_and_alu_execute.sv
`timescale 1ns / 1ps
// Top level of the CHIP-8 execute block: input register, execute stage, result register.
// Depends on c8ex_pkg, c8ex_if, c8ex_exec, c8ex_vregs and c8ex_stack.

// Takes one CHIP-8 instruction word per transaction, fetched at the program counter
// reported by the previous result, and returns one result per instruction. Sustained
// rate is one instruction per clock while o_out.ready does not hold the output. Vx and
// Vy are read into registers when the word is accepted, along with the word; decode,
// ALU and writeback of PC, V registers and return stack then land in the result
// register when the execute stage advances. A new instruction is taken while the previous
// result still waits on the output. Writing the start address loads the program
// counter at once; after reset it is 0x200.
module chip8_control_and_alu_execute (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [c8ex_pkg::PC_W-1:0] i_cfg_wr_data,
    c8ex_in_if.sink                   i_in,
    c8ex_out_if.source                o_out
);
    import c8ex_pkg::*;

    logic                   r_ex_valid;
    logic [INSTR_W-1:0]     r_ex_word;
    logic                   r_out_valid;
    t_result                r_out;
    logic [DEPTH_OUT_W-1:0] r_out_depth;
    logic [PC_W-1:0]        r_pc;
    logic                   ex_adv;
    logic                   in_acc;
    logic [DATA_W-1:0]      vx;
    logic [DATA_W-1:0]      vy;
    logic [CNT_W-1:0]       count;
    logic [CNT_W-1:0]       n_count;
    logic [PC_W-1:0]        tos;
    t_result                res;
    t_vwrite                vwr;
    t_stack_op              sop;

    assign ex_adv     = r_ex_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_ex_valid || ex_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    c8ex_vregs u_vregs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (ex_adv),
        .i_wr    (vwr),
        .i_rd_en (in_acc),
        .i_rd_x  (i_in.instruction_word[11:8]),
        .i_rd_y  (i_in.instruction_word[7:4]),
        .o_vx    (vx),
        .o_vy    (vy)
    );

    c8ex_stack u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (ex_adv),
        .i_op      (sop),
        .o_count   (count),
        .o_n_count (n_count),
        .o_tos     (tos)
    );

    c8ex_exec u_exec (
        .i_word  (r_ex_word),
        .i_vx    (vx),
        .i_vy    (vy),
        .i_pc    (r_pc),
        .i_count (count),
        .i_tos   (tos),
        .o_res   (res),
        .o_vwr   (vwr),
        .o_sop   (sop)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= START_RESET;
        end else begin
            if (in_acc) begin
                r_ex_valid <= 1'b1;
            end else if (ex_adv) begin
                r_ex_valid <= 1'b0;
            end
            if (ex_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_pc <= i_cfg_wr_data;
            end else if (ex_adv) begin
                r_pc <= res.next_pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ex_word <= i_in.instruction_word;
        end
        if (ex_adv) begin
            r_out       <= res;
            r_out_depth <= DEPTH_OUT_W'(n_count);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.next_pc     = r_out.next_pc;
    assign o_out.reg_written = r_out.reg_written;
    assign o_out.reg_index   = r_out.reg_index;
    assign o_out.reg_value   = r_out.reg_value;
    assign o_out.flag_value  = r_out.flag_value;
    assign o_out.skip_taken  = r_out.skip_taken;
    assign o_out.stack_depth = r_out_depth;
    assign o_out.stack_error = r_out.stack_error;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(STACK_DEPTH))
        else $error("return stack count beyond depth");

    a_err_holds_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_adv && res.stack_error |=> count == $past(count))
        else $error("stack changed on stack error");

    a_ex_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex_valid && !ex_adv |=> r_ex_valid && $stable(r_ex_word))
        else $error("stalled instruction lost");

    a_skip_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.skip_taken |-> !r_out.reg_written && !r_out.stack_error)
        else $error("skip result also wrote state");
`endif

endmodule

### src/c8ex_exec.sv
`timescale 1ns / 1ps
// Decode, ALU, skip and branch logic for one instruction word.
// Depends on c8ex_pkg; produces result, V register write and stack operation.
module c8ex_exec (
    input  logic [c8ex_pkg::INSTR_W-1:0] i_word,
    input  logic [c8ex_pkg::DATA_W-1:0]  i_vx,
    input  logic [c8ex_pkg::DATA_W-1:0]  i_vy,
    input  logic [c8ex_pkg::PC_W-1:0]    i_pc,
    input  logic [c8ex_pkg::CNT_W-1:0]   i_count,
    input  logic [c8ex_pkg::PC_W-1:0]    i_tos,
    output c8ex_pkg::t_result            o_res,
    output c8ex_pkg::t_vwrite            o_vwr,
    output c8ex_pkg::t_stack_op          o_sop
);
    import c8ex_pkg::*;

    logic [3:0]        op;
    logic [IDX_W-1:0]  x;
    logic [3:0]        n;
    logic [DATA_W-1:0] kk;
    logic [PC_W-1:0]   nnn;
    logic [PC_W-1:0]   pc2;
    logic [PC_W-1:0]   next;
    logic [DATA_W:0]   sum;
    logic              written;
    logic              has_flag;
    logic              flag;
    logic              skip;
    logic              err;
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] result;

    assign op  = i_word[15:12];
    assign x   = i_word[11:8];
    assign n   = i_word[3:0];
    assign kk  = i_word[7:0];
    assign nnn = i_word[PC_W-1:0];
    assign pc2 = i_pc + PC_W'(2);
    assign sum = {1'b0, i_vx} + {1'b0, i_vy};

    always_comb begin
        next     = pc2;
        written  = 1'b0;
        has_flag = 1'b0;
        flag     = 1'b0;
        skip     = 1'b0;
        err      = 1'b0;
        push     = 1'b0;
        pop      = 1'b0;
        result   = '0;
        case (op)
            OP_SYS: begin
                if (i_word == W_RET) begin
                    if (i_count == '0) begin
                        err = 1'b1;
                    end else begin
                        pop  = 1'b1;
                        next = i_tos;
                    end
                end
            end
            OP_JP: begin
                next = nnn;
            end
            OP_CALL: begin
                if (i_count >= CNT_W'(STACK_DEPTH)) begin
                    err = 1'b1;
                end else begin
                    push = 1'b1;
                    next = nnn;
                end
            end
            OP_SE_K:  skip = (i_vx == kk);
            OP_SNE_K: skip = (i_vx != kk);
            OP_SE_R:  skip = (n == 4'h0) && (i_vx == i_vy);
            OP_LD_K: begin
                written = 1'b1;
                result  = kk;
            end
            OP_ADD_K: begin
                written = 1'b1;
                result  = i_vx + kk;
            end
            OP_ALU: begin
                written = 1'b1;
                case (n)
                    ALU_LD:  result = i_vy;
                    ALU_OR:  result = i_vx | i_vy;
                    ALU_AND: result = i_vx & i_vy;
                    ALU_XOR: result = i_vx ^ i_vy;
                    ALU_ADD: begin
                        result   = sum[DATA_W-1:0];
                        flag     = sum[DATA_W];
                        has_flag = 1'b1;
                    end
                    ALU_SUB: begin
                        result   = i_vx - i_vy;
                        flag     = (i_vx >= i_vy);
                        has_flag = 1'b1;
                    end
                    ALU_SHR: begin
                        result   = i_vx >> 1;
                        flag     = i_vx[0];
                        has_flag = 1'b1;
                    end
                    ALU_SUBN: begin
                        result   = i_vy - i_vx;
                        flag     = (i_vy >= i_vx);
                        has_flag = 1'b1;
                    end
                    ALU_SHL: begin
                        result   = i_vx << 1;
                        flag     = i_vx[DATA_W-1];
                        has_flag = 1'b1;
                    end
                    default: written = 1'b0;
                endcase
            end
            default: ;
        endcase
        if (skip) begin
            next = pc2 + PC_W'(2);
        end
    end

    assign o_res.next_pc     = next;
    assign o_res.reg_written = written;
    assign o_res.reg_index   = written ? x : '0;
    assign o_res.reg_value   = written ? result : '0;
    assign o_res.flag_value  = has_flag & flag;
    assign o_res.skip_taken  = skip;
    assign o_res.stack_error = err;

    assign o_vwr.we      = written && (x != VF_IDX);
    assign o_vwr.idx     = x;
    assign o_vwr.data    = result;
    assign o_vwr.vf_we   = has_flag || (written && (x == VF_IDX));
    assign o_vwr.vf_data = has_flag ? DATA_W'(flag) : result;

    assign o_sop.push      = push;
    assign o_sop.pop       = pop;
    assign o_sop.push_addr = pc2;

endmodule

### src/c8ex_vregs.sv
`timescale 1ns / 1ps
// V register file: V0..VE in a memory with valid bits, VF in its own register.
// Registered read of Vx/Vy with write bypass. Depends on c8ex_pkg.
module c8ex_vregs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  c8ex_pkg::t_vwrite           i_wr,
    input  logic                        i_rd_en,
    input  logic [c8ex_pkg::IDX_W-1:0]  i_rd_x,
    input  logic [c8ex_pkg::IDX_W-1:0]  i_rd_y,
    output logic [c8ex_pkg::DATA_W-1:0] o_vx,
    output logic [c8ex_pkg::DATA_W-1:0] o_vy
);
    import c8ex_pkg::*;

    logic [DATA_W-1:0] mem [NUM_V];
    logic [NUM_V-1:0]  r_valid;
    logic [DATA_W-1:0] r_vf;
    logic [DATA_W-1:0] n_vf;
    logic [DATA_W-1:0] r_x_mem;
    logic [DATA_W-1:0] r_y_mem;
    logic              r_x_alt;
    logic              r_y_alt;
    logic [DATA_W-1:0] r_x_alt_val;
    logic [DATA_W-1:0] r_y_alt_val;
    logic              we;
    logic              x_hit;
    logic              y_hit;
    logic              n_x_alt;
    logic              n_y_alt;
    logic [DATA_W-1:0] n_x_alt_val;
    logic [DATA_W-1:0] n_y_alt_val;

    assign we    = i_wr_en && i_wr.we;
    assign n_vf  = (i_wr_en && i_wr.vf_we) ? i_wr.vf_data : r_vf;
    assign x_hit = we && (i_wr.idx == i_rd_x);
    assign y_hit = we && (i_wr.idx == i_rd_y);

    assign n_x_alt     = (i_rd_x == VF_IDX) || x_hit || !r_valid[i_rd_x];
    assign n_y_alt     = (i_rd_y == VF_IDX) || y_hit || !r_valid[i_rd_y];
    assign n_x_alt_val = (i_rd_x == VF_IDX) ? n_vf : (x_hit ? i_wr.data : '0);
    assign n_y_alt_val = (i_rd_y == VF_IDX) ? n_vf : (y_hit ? i_wr.data : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vf    <= '0;
        end else begin
            r_vf <= n_vf;
            if (we) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_x_mem     <= mem[i_rd_x];
            r_y_mem     <= mem[i_rd_y];
            r_x_alt     <= n_x_alt;
            r_y_alt     <= n_y_alt;
            r_x_alt_val <= n_x_alt_val;
            r_y_alt_val <= n_y_alt_val;
        end
    end

    assign o_vx = r_x_alt ? r_x_alt_val : r_x_mem;
    assign o_vy = r_y_alt ? r_y_alt_val : r_y_mem;

endmodule

### src/c8ex_stack.sv
`timescale 1ns / 1ps
// Return stack: entry memory, fill count and registered top-of-stack.
// Depends on c8ex_pkg for depth and widths.
module c8ex_stack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  c8ex_pkg::t_stack_op        i_op,
    output logic [c8ex_pkg::CNT_W-1:0] o_count,
    output logic [c8ex_pkg::CNT_W-1:0] o_n_count,
    output logic [c8ex_pkg::PC_W-1:0]  o_tos
);
    import c8ex_pkg::*;

    logic [PC_W-1:0]  mem [STACK_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] below_top;
    logic [PC_W-1:0]  r_tos;

    assign below_top = r_count - CNT_W'(2);

    always_comb begin
        n_count = r_count;
        if (i_en && i_op.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_en && i_op.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_op.push) begin
            mem[r_count[SP_W-1:0]] <= i_op.push_addr;
            r_tos                  <= i_op.push_addr;
        end else if (i_en && i_op.pop) begin
            r_tos <= mem[below_top[SP_W-1:0]];
        end
    end

    assign o_count   = r_count;
    assign o_n_count = n_count;
    assign o_tos     = r_tos;

endmodule

### tb/sv/chip8_control_and_alu_execute_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for chip8_control_and_alu_execute: directed and random
// instruction streams, an in-order execute predictor, random idling on both channels.
// Depends on c8ex_pkg, c8ex_if and the execute block RTL.
module chip8_control_and_alu_execute_test;
    import c8ex_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_WAIT     = 12;
    localparam int REPORT_LIMIT = 10;

    localparam logic [INSTR_W-1:0] W_CLS             = 16'h00E0;
    localparam logic [3:0]         OP_FIRST_UNUSED   = 4'h9;
    localparam logic [3:0]         ALU_FIRST_UNUSED  = 4'h8;

    typedef struct packed {
        logic [PC_W-1:0]        next_pc;
        logic                   reg_written;
        logic [IDX_W-1:0]       reg_index;
        logic [DATA_W-1:0]      reg_value;
        logic                   flag_value;
        logic                   skip_taken;
        logic [DEPTH_OUT_W-1:0] stack_depth;
        logic                   stack_error;
    } t_exec_outcome;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [PC_W-1:0] i_cfg_wr_data;

    c8ex_in_if  in_ch ();
    c8ex_out_if out_ch ();

    chip8_control_and_alu_execute DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // Predictor state
    logic [PC_W-1:0]   pc_model;
    logic [DATA_W-1:0] v_model [NUM_V];
    logic [PC_W-1:0]   call_stack [STACK_DEPTH];
    int                call_depth;

    logic [INSTR_W-1:0] pending_words [$];
    t_exec_outcome      expected_outcomes [$];
    int                 emitted;
    int                 mismatch_count;
    int                 cycle_count;
    int                 gap_left;
    int                 stall_left;
    bit                 in_burst;
    bit                 out_burst;

    function automatic t_exec_outcome execute_instruction(logic [INSTR_W-1:0] w);
        logic [3:0]        op, x, y, n;
        logic [DATA_W-1:0] kk, vx, vy, res;
        logic [DATA_W:0]   sum;
        logic [PC_W-1:0]   nnn, pc2, nxt;
        bit                wr, has_flag, skip, err;
        logic              flag;
        t_exec_outcome     r;
        op = w[15:12];
        x = w[11:8];
        y = w[7:4];
        n = w[3:0];
        kk = w[7:0];
        nnn = w[11:0];
        vx = v_model[x];
        vy = v_model[y];
        pc2 = pc_model + 12'd2;
        nxt = pc2;
        wr = 0;
        has_flag = 0;
        skip = 0;
        err = 0;
        flag = 1'b0;
        res = '0;
        case (op)
            OP_SYS: begin
                if (w == W_RET) begin
                    if (call_depth == 0) begin
                        err = 1;
                    end else begin
                        call_depth--;
                        nxt = call_stack[call_depth];
                    end
                end
            end
            OP_JP: nxt = nnn;
            OP_CALL: begin
                if (call_depth >= STACK_DEPTH) begin
                    err = 1;
                end else begin
                    call_stack[call_depth] = pc2;
                    call_depth++;
                    nxt = nnn;
                end
            end
            OP_SE_K:  skip = (vx == kk);
            OP_SNE_K: skip = (vx != kk);
            OP_SE_R:  skip = (n == 4'h0) && (vx == vy);
            OP_LD_K: begin
                wr = 1;
                res = kk;
            end
            OP_ADD_K: begin
                wr = 1;
                res = vx + kk;
            end
            OP_ALU: begin
                wr = 1;
                case (n)
                    ALU_LD:  res = vy;
                    ALU_OR:  res = vx | vy;
                    ALU_AND: res = vx & vy;
                    ALU_XOR: res = vx ^ vy;
                    ALU_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        res = sum[DATA_W-1:0];
                        flag = sum[DATA_W];
                        has_flag = 1;
                    end
                    ALU_SUB: begin
                        res = vx - vy;
                        flag = (vx >= vy);
                        has_flag = 1;
                    end
                    ALU_SHR: begin
                        res = vx >> 1;
                        flag = vx[0];
                        has_flag = 1;
                    end
                    ALU_SUBN: begin
                        res = vy - vx;
                        flag = (vy >= vx);
                        has_flag = 1;
                    end
                    ALU_SHL: begin
                        res = {vx[DATA_W-2:0], 1'b0};
                        flag = vx[DATA_W-1];
                        has_flag = 1;
                    end
                    default: wr = 0;
                endcase
            end
            default: ;
        endcase
        if (skip) nxt = pc2 + 12'd2;
        if (wr) v_model[x] = res;
        if (has_flag) v_model[VF_IDX] = {7'b0, flag};
        pc_model = nxt;
        r.next_pc     = nxt;
        r.reg_written = wr;
        r.reg_index   = wr ? x : '0;
        r.reg_value   = wr ? res : '0;
        r.flag_value  = has_flag ? flag : 1'b0;
        r.skip_taken  = skip;
        r.stack_depth = DEPTH_OUT_W'(call_depth);
        r.stack_error = err;
        return r;
    endfunction

    function automatic int pick_wait(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [3:0] pick_alu_op();
        case ($urandom_range(0, 9))
            0: return ALU_LD;
            1: return ALU_OR;
            2: return ALU_AND;
            3: return ALU_XOR;
            4: return ALU_ADD;
            5: return ALU_SUB;
            6: return ALU_SHR;
            7: return ALU_SUBN;
            8: return ALU_SHL;
            default: return 4'($urandom_range(ALU_FIRST_UNUSED, ALU_SHL - 1));
        endcase
    endfunction

    function automatic void emit(logic [INSTR_W-1:0] w);
        pending_words.push_back(w);
        emitted++;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Instruction driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_outcomes.push_back(execute_instruction(in_ch.instruction_word));
                if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
                gap_left = pick_wait(in_burst);
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold until accepted
            end else if (gap_left != 0) begin
                in_ch.valid <= 1'b0;
                gap_left--;
            end else if (pending_words.size() != 0) begin
                in_ch.valid <= 1'b1;
                in_ch.instruction_word <= pending_words.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_exec_outcome got;
        t_exec_outcome want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{next_pc: out_ch.next_pc, reg_written: out_ch.reg_written,
                        reg_index: out_ch.reg_index, reg_value: out_ch.reg_value,
                        flag_value: out_ch.flag_value, skip_taken: out_ch.skip_taken,
                        stack_depth: out_ch.stack_depth, stack_error: out_ch.stack_error};
                if (expected_outcomes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Unexpected result transaction: pc=%03h", got.next_pc);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("Mismatch expected: pc=%03h wr=%0d idx=%0h val=%02h f=%0d skip=%0d depth=%0d err=%0d",
                                     want.next_pc, want.reg_written, want.reg_index,
                                     want.reg_value, want.flag_value, want.skip_taken,
                                     want.stack_depth, want.stack_error);
                            $display("         actual:   pc=%03h wr=%0d idx=%0h val=%02h f=%0d skip=%0d depth=%0d err=%0d",
                                     got.next_pc, got.reg_written, got.reg_index,
                                     got.reg_value, got.flag_value, got.skip_taken,
                                     got.stack_depth, got.stack_error);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
                stall_left = pick_wait(out_burst);
            end
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || in_ch.valid || expected_outcomes.size() != 0);
    endtask

    task automatic load_start(logic [PC_W-1:0] addr);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        pc_model = addr;
    endtask

    task automatic queue_directed();
        emit({OP_LD_K, 4'h0, 8'hFF});
        emit({OP_LD_K, 4'h1, 8'h01});
        emit({OP_ALU, 4'h0, 4'h1, ALU_ADD});
        emit({OP_LD_K, VF_IDX, 8'hFF});
        emit({OP_ALU, VF_IDX, 4'h1, ALU_ADD});
        emit({OP_ALU, 4'h0, 4'h1, ALU_SUB});
        emit({OP_ALU, 4'h0, 4'h1, ALU_SUBN});
        emit({OP_LD_K, 4'h2, 8'hFF});
        emit({OP_ALU, 4'h2, 4'h2, ALU_SHL});
        emit({OP_ALU, 4'h2, 4'h2, ALU_SHR});
        emit({OP_ALU, 4'h2, 4'h2, ALU_SHR});
        emit({OP_ALU, 4'h3, 4'h2, ALU_LD});
        emit({OP_ALU, 4'h3, 4'h1, ALU_OR});
        emit({OP_ALU, 4'h3, 4'h0, ALU_AND});
        emit({OP_ALU, 4'hE, 4'h2, ALU_XOR});
        emit({OP_ALU, 4'h4, 4'h2, ALU_FIRST_UNUSED});
        emit({OP_ADD_K, 4'h1, 8'hFF});
        emit({OP_SE_K, 4'h1, 8'h00});
        emit({OP_SNE_K, 4'h1, 8'h00});
        emit({OP_SE_R, 4'h3, 4'h2, 4'h0});
        emit({OP_SE_R, 4'h3, 4'h2, 4'h1});
        emit(W_CLS);
        emit(W_RET);
        emit({OP_SYS, 12'hFFF});
        emit({OP_JP, 12'hFFF});
        emit({OP_CALL, 12'h000});
        emit(W_RET);
        emit({OP_FIRST_UNUSED, 12'h000});
        emit(16'hFFFF);
    endtask

    // Nest past the stack limit, then unwind past empty
    task automatic queue_deep_nest();
        int depth;
        depth = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 3);
        repeat (depth) emit({OP_CALL, 12'($urandom)});
        repeat (depth + 1) emit(W_RET);
    endtask

    task automatic queue_program(int count);
        int target;
        int depth;
        logic [3:0] x, y;
        logic [DATA_W-1:0] kk;
        target = emitted + count;
        while (emitted < target) begin
            x = 4'($urandom);
            y = 4'($urandom);
            kk = 8'($urandom);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: begin
                    emit({OP_LD_K, x, kk});
                    emit({OP_LD_K, y, $urandom_range(0, 3) == 0 ? kk : 8'($urandom)});
                    emit({OP_ALU, x, y, pick_alu_op()});
                    if ($urandom_range(0, 1) == 0) emit({OP_ADD_K, x, 8'($urandom)});
                end
                6, 7, 8: begin
                    emit({OP_LD_K, x, kk});
                    emit({$urandom_range(0, 1) ? OP_SE_K : OP_SNE_K, x,
                          $urandom_range(0, 1) ? kk : 8'($urandom)});
                    if ($urandom_range(0, 1) == 0) emit({OP_ALU, y, x, ALU_LD});
                    emit({OP_SE_R, x, y, $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'h0});
                end
                9, 10, 11, 12: begin
                    depth = $urandom_range(1, 5);
                    repeat (depth) begin
                        emit({OP_CALL, 12'($urandom)});
                        if ($urandom_range(0, 1) == 0) emit({OP_ALU, x, y, pick_alu_op()});
                    end
                    repeat (depth + $urandom_range(0, 1)) emit(W_RET);
                end
                13: emit({OP_JP, 12'($urandom)});
                14: queue_deep_nest();
                default: emit(16'($urandom));
            endcase
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        in_ch.valid    = 1'b0;
        in_ch.instruction_word = '0;
        out_ch.ready   = 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        emitted        = 0;
        in_burst       = 0;
        out_burst      = 0;
        pc_model       = START_RESET;
        call_depth     = 0;
        foreach (v_model[i]) v_model[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        wait_drained();

        load_start(12'hFFF);
        queue_deep_nest();
        queue_program(100);
        wait_drained();

        load_start(12'h000);
        queue_program(110);
        wait_drained();

        load_start(12'($urandom_range(1, 4094)));
        queue_program(110);
        wait_drained();

        load_start(12'($urandom_range(1, 4094)));
        queue_program(110);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
